FILE: sv/jets_pkg.sv
`default_nettype none
package jets_pkg;

    localparam int unsigned PIX_W   = 10;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned SEQ_W   = 2;
    localparam int unsigned CFG_A_W = 3;
    localparam int unsigned WIDE_W  = 66;

    localparam int unsigned DEF_COORD_BITS = 10;
    localparam int unsigned DEF_FRAC_BITS  = 28;

    localparam logic [CFG_A_W-1:0] REG_C_RE     = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_C_IM     = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_X_ORIGIN = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_Y_ORIGIN = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_X_STEP   = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_Y_STEP   = 3'd5;
    localparam logic [CFG_A_W-1:0] REG_ITER_LIM = 3'd6;

    localparam logic [VAL_W-1:0] RST_C_RE     = 32'sd76504269;
    localparam logic [VAL_W-1:0] RST_C_IM     = 32'sd2684355;
    localparam logic [VAL_W-1:0] RST_X_ORIGIN = -32'sd402653184;
    localparam logic [VAL_W-1:0] RST_Y_ORIGIN = -32'sd268435456;
    localparam logic [VAL_W-1:0] RST_X_STEP   = 32'sd2516582;
    localparam logic [VAL_W-1:0] RST_Y_STEP   = 32'sd2236962;
    localparam logic [CNT_W-1:0] RST_ITER_LIM = 8'd30;

    typedef struct packed {
        logic                    occ;
        logic                    fresh;
        logic                    done;
        logic [SEQ_W-1:0]        seq;
        logic [PIX_W-1:0]        px;
        logic [PIX_W-1:0]        py;
        logic [CNT_W-1:0]        cnt;
        logic signed [VAL_W-1:0] zx;
        logic signed [VAL_W-1:0] zy;
    } t_slot;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    function automatic t_rgb pal_lookup(input logic [3:0] idx);
        t_rgb c;
        case (idx)
            4'd0:    c = '{8'd0,   8'd0,   8'd0};
            4'd1:    c = '{8'd0,   8'd0,   8'd170};
            4'd2:    c = '{8'd0,   8'd170, 8'd0};
            4'd3:    c = '{8'd0,   8'd170, 8'd170};
            4'd4:    c = '{8'd170, 8'd0,   8'd0};
            4'd5:    c = '{8'd170, 8'd0,   8'd170};
            4'd6:    c = '{8'd170, 8'd85,  8'd0};
            4'd7:    c = '{8'd170, 8'd170, 8'd170};
            4'd8:    c = '{8'd85,  8'd85,  8'd85};
            4'd9:    c = '{8'd85,  8'd85,  8'd255};
            4'd10:   c = '{8'd85,  8'd255, 8'd85};
            4'd11:   c = '{8'd85,  8'd255, 8'd255};
            4'd12:   c = '{8'd255, 8'd85,  8'd85};
            4'd13:   c = '{8'd255, 8'd85,  8'd255};
            4'd14:   c = '{8'd255, 8'd255, 8'd85};
            default: c = '{8'd255, 8'd255, 8'd255};
        endcase
        return c;
    endfunction

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(64'sh7FFF_FFFF);
        lo = -WIDE_W'(64'sh8000_0000);
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[VAL_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: sv/julia_escape_time_pixel_top.sv
`default_nettype none
// channel | dir | handshake                | payload
// s       | in  | i_s_tvalid / o_s_tready  | i_s_tdata  pix_x, pix_y
// m       | out | o_m_tvalid / i_m_tready  | o_m_tdata  out_x, out_y, iterations, inside_res, rgb
// cfg     | in  | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
// Three-stage iteration ring (multiply, add/shift/escape compare, saturate).
// Up to three pixels circulate. A pixel makes a first pass to load its start point,
// then one pass per iteration, plus a last pass on which it escapes unless it hits
// the iteration limit (30 after reset).
// Results leave in input order; a finished pixel keeps circulating until its turn
// and the output register are free. Reset empties the ring and output register.
module julia_escape_time_pixel_top #(
    parameter int unsigned COORD_BITS = jets_pkg::DEF_COORD_BITS,
    parameter int unsigned FRAC_BITS  = jets_pkg::DEF_FRAC_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // pix_x[9:0], pix_y[19:10], zero fill
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [55:0]      o_m_tdata,   // out_x, out_y, iterations, inside_res, red, green, blue
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int unsigned CB = (COORD_BITS < jets_pkg::PIX_W) ? COORD_BITS : jets_pkg::PIX_W;
    localparam logic [jets_pkg::PIX_W-1:0] PIX_MASK = jets_pkg::PIX_W'((64'd1 << CB) - 64'd1);
    localparam logic [63:0] ESC_LIM = 64'd4 << (2 * FRAC_BITS);
    localparam int unsigned W = jets_pkg::WIDE_W;

    logic signed [31:0] r_c_re, r_c_im, r_x_origin, r_y_origin, r_x_step, r_y_step;
    logic [7:0]         r_iter_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_re       <= jets_pkg::RST_C_RE;
            r_c_im       <= jets_pkg::RST_C_IM;
            r_x_origin   <= jets_pkg::RST_X_ORIGIN;
            r_y_origin   <= jets_pkg::RST_Y_ORIGIN;
            r_x_step     <= jets_pkg::RST_X_STEP;
            r_y_step     <= jets_pkg::RST_Y_STEP;
            r_iter_limit <= jets_pkg::RST_ITER_LIM;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                jets_pkg::REG_C_RE:     r_c_re       <= i_cfg_data;
                jets_pkg::REG_C_IM:     r_c_im       <= i_cfg_data;
                jets_pkg::REG_X_ORIGIN: r_x_origin   <= i_cfg_data;
                jets_pkg::REG_Y_ORIGIN: r_y_origin   <= i_cfg_data;
                jets_pkg::REG_X_STEP:   r_x_step     <= i_cfg_data;
                jets_pkg::REG_Y_STEP:   r_y_step     <= i_cfg_data;
                jets_pkg::REG_ITER_LIM: r_iter_limit <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    jets_pkg::t_slot r1_slot, r2_slot, r3_slot, n_e, n3_slot;
    logic signed [63:0] r1_a, r1_b, r1_p;
    logic signed [W-1:0] r2_na, r2_nb;
    logic                r2_esc;
    logic [1:0]          r_iseq, r_oseq;
    logic                r_ov;
    logic [55:0]         r_odata;

    // ring entry
    logic lim_hit, done_eff, out_free, retire, accept;
    jets_pkg::t_rgb w_rgb;
    logic w_inside;

    assign lim_hit  = r3_slot.occ && !r3_slot.done && !r3_slot.fresh
                      && (r3_slot.cnt == r_iter_limit);
    assign done_eff = r3_slot.done || lim_hit;
    assign out_free = !r_ov || i_m_tready;
    assign retire   = r3_slot.occ && done_eff && (r3_slot.seq == r_oseq) && out_free;
    assign accept   = !r3_slot.occ && i_s_tvalid;
    assign o_s_tready = !r3_slot.occ;

    always_comb begin
        n_e = r3_slot;
        n_e.done = done_eff;
        if (accept) begin
            n_e.occ   = 1'b1;
            n_e.fresh = 1'b1;
            n_e.done  = 1'b0;
            n_e.seq   = r_iseq;
            n_e.px    = i_s_tdata[9:0] & PIX_MASK;
            n_e.py    = i_s_tdata[19:10] & PIX_MASK;
            n_e.cnt   = '0;
        end else if (retire) begin
            n_e.occ = 1'b0;
        end
    end

    assign w_inside = (r3_slot.cnt == r_iter_limit);
    assign w_rgb    = jets_pkg::pal_lookup(w_inside ? 4'd0 : r3_slot.cnt[3:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_iseq <= '0;
            r_oseq <= '0;
        end else begin
            if (accept) r_iseq <= r_iseq + 2'd1;
            if (retire) begin
                r_oseq <= r_oseq + 2'd1;
                r_ov   <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (retire) begin
            r_odata <= {3'b000, w_rgb.blue, w_rgb.green, w_rgb.red, w_inside,
                        r3_slot.cnt, r3_slot.py, r3_slot.px};
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_odata;

    // stage 1: multiply
    logic signed [42:0] w_mx, w_my;
    assign w_mx = $signed({1'b0, n_e.px}) * r_x_step;
    assign w_my = $signed({1'b0, n_e.py}) * r_y_step;

    always_ff @(posedge i_clk) begin
        if (n_e.fresh) begin
            r1_a <= {{21{w_mx[42]}}, w_mx};
            r1_b <= {{21{w_my[42]}}, w_my};
            r1_p <= '0;
        end else begin
            r1_a <= n_e.zx * n_e.zx;
            r1_b <= n_e.zy * n_e.zy;
            r1_p <= n_e.zx * n_e.zy;
        end
        if (!i_rst_n) begin
            r1_slot <= '0;
        end else begin
            r1_slot <= n_e;
        end
    end

    // stage 2: add, scale, escape compare
    logic [63:0]        w_mag;
    logic signed [63:0] w_diff, w_dsh, w_psh;
    assign w_mag  = r1_a + r1_b;
    assign w_diff = r1_a - r1_b;
    assign w_dsh  = w_diff >>> FRAC_BITS;
    assign w_psh  = r1_p >>> (FRAC_BITS - 1);

    always_ff @(posedge i_clk) begin
        if (r1_slot.fresh) begin
            r2_na <= $signed({{2{r1_a[63]}}, r1_a}) + $signed({{34{r_x_origin[31]}}, r_x_origin});
            r2_nb <= $signed({{2{r1_b[63]}}, r1_b}) + $signed({{34{r_y_origin[31]}}, r_y_origin});
        end else begin
            r2_na <= $signed({{2{w_dsh[63]}}, w_dsh}) + $signed({{34{r_c_re[31]}}, r_c_re});
            r2_nb <= $signed({{2{w_psh[63]}}, w_psh}) + $signed({{34{r_c_im[31]}}, r_c_im});
        end
        r2_esc  <= (w_mag >= ESC_LIM);
        if (!i_rst_n) begin
            r2_slot <= '0;
        end else begin
            r2_slot <= r1_slot;
        end
    end

    // stage 3: saturate and update state
    always_comb begin
        n3_slot = r2_slot;
        if (r2_slot.occ && !r2_slot.done) begin
            if (r2_slot.fresh) begin
                n3_slot.fresh = 1'b0;
                n3_slot.zx    = jets_pkg::sat32(r2_na);
                n3_slot.zy    = jets_pkg::sat32(r2_nb);
            end else if (r2_esc) begin
                n3_slot.done = 1'b1;
            end else begin
                n3_slot.zx  = jets_pkg::sat32(r2_na);
                n3_slot.zy  = jets_pkg::sat32(r2_nb);
                n3_slot.cnt = r2_slot.cnt + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_slot <= '0;
        end else begin
            r3_slot <= n3_slot;
        end
    end

    logic [1:0] w_inflight;
    assign w_inflight = r_iseq - r_oseq;

    a_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(w_inflight) == $countones({r1_slot.occ, r2_slot.occ, r3_slot.occ}))
        else $error("ring occupancy does not match sequence tags");

    a_inside_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[28] |-> o_m_tdata[52:29] == 24'd0)
        else $error("inside pixel not black");

    a_cnt_le_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[27:20] <= r_iter_limit)
        else $error("iteration count above limit");

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none
class pixel_scoreboard;
    logic [55:0] expected_words[$];
    int          errors;
    logic signed [31:0] c_re, c_im, x_org, y_org, x_stp, y_stp;
    logic [7:0]  lim;

    function void set_defaults();
        c_re  = jets_pkg::RST_C_RE;
        c_im  = jets_pkg::RST_C_IM;
        x_org = jets_pkg::RST_X_ORIGIN;
        y_org = jets_pkg::RST_Y_ORIGIN;
        x_stp = jets_pkg::RST_X_STEP;
        y_stp = jets_pkg::RST_Y_STEP;
        lim   = jets_pkg::RST_ITER_LIM;
        errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            jets_pkg::REG_C_RE:     c_re  = val;
            jets_pkg::REG_C_IM:     c_im  = val;
            jets_pkg::REG_X_ORIGIN: x_org = val;
            jets_pkg::REG_Y_ORIGIN: y_org = val;
            jets_pkg::REG_X_STEP:   x_stp = val;
            jets_pkg::REG_Y_STEP:   y_stp = val;
            jets_pkg::REG_ITER_LIM: lim   = val[7:0];
            default: ;
        endcase
    endfunction

    static function logic signed [31:0] clamp(logic signed [79:0] v);
        if (v > 80'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -80'sh8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function void note_pixel(logic [9:0] px, logic [9:0] py);
        logic signed [31:0] zx, zy;
        logic signed [79:0] sx, sy, prod;
        logic [7:0]  count;
        logic        in_set;
        logic [3:0]  idx;
        logic [7:0]  r, g, b;
        zx = clamp(80'(x_org) + 80'($signed({1'b0, px})) * 80'(x_stp));
        zy = clamp(80'(y_org) + 80'($signed({1'b0, py})) * 80'(y_stp));
        count = 0;
        while (count < lim) begin
            sx = 80'(zx) * 80'(zx);
            sy = 80'(zy) * 80'(zy);
            if (sx + sy >= (80'sd4 <<< 56)) break;
            prod = 80'(zx) * 80'(zy);
            zx = clamp(((sx - sy) >>> 28) + 80'(c_re));
            zy = clamp((prod >>> 27) + 80'(c_im));
            count++;
        end
        in_set = (count == lim);
        idx = in_set ? 4'd0 : count[3:0];
        r = (idx[2] ? 8'd170 : 8'd0) + (idx[3] ? 8'd85 : 8'd0);
        g = (idx[1] ? 8'd170 : 8'd0) + (idx[3] ? 8'd85 : 8'd0);
        b = (idx[0] ? 8'd170 : 8'd0) + (idx[3] ? 8'd85 : 8'd0);
        if (idx == 4'd6) g = 8'd85;
        expected_words.push_back({3'b000, b, g, r, in_set, count, py, px});
    endfunction

    function void check_word(logic [55:0] got);
        logic [55:0] exp_w;
        if (expected_words.size() == 0) begin
            $display("%0t unexpected pixel result %h", $time, got);
            errors++;
            return;
        end
        exp_w = expected_words.pop_front();
        if (got[9:0] !== exp_w[9:0])
            $display("%0t out_x exp %0d got %0d", $time, exp_w[9:0], got[9:0]);
        if (got[19:10] !== exp_w[19:10])
            $display("%0t out_y exp %0d got %0d", $time, exp_w[19:10], got[19:10]);
        if (got[27:20] !== exp_w[27:20])
            $display("%0t iterations exp %0d got %0d", $time, exp_w[27:20], got[27:20]);
        if (got[28] !== exp_w[28])
            $display("%0t inside exp %0d got %0d", $time, exp_w[28], got[28]);
        if (got[52:29] !== exp_w[52:29])
            $display("%0t rgb exp %h got %h", $time, exp_w[52:29], got[52:29]);
        if (got[52:0] !== exp_w[52:0]) errors++;
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk, i_rst_n;
    logic        i_s_tvalid, o_s_tready;
    logic [23:0] i_s_tdata;
    logic        o_m_tvalid, i_m_tready;
    logic [55:0] o_m_tdata;
    logic        i_cfg_valid, o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    pixel_scoreboard pixels;
    int          send_idle_pct, recv_idle_pct;
    int          quiet_cycles;
    logic        stim_done;

    julia_escape_time_pixel_top DUT (.*);

    function automatic logic o_s_tvalid_acc();
        return i_s_tvalid && o_s_tready;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stim_done = 1'b0;
        pixels = new();
        pixels.set_defaults();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // receiver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) pixels.check_word(o_m_tdata);
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (o_s_tvalid_acc() || (o_m_tvalid && i_m_tready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_pixel(logic [9:0] px, logic [9:0] py);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {4'b0, py, px};
        do @(posedge i_clk); while (!o_s_tready);
        pixels.note_pixel(px, py);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pixels.expected_words.size() != 0) @(posedge i_clk);
        repeat (800) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        pixels.write_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_view(logic [31:0] cr, logic [31:0] ci, logic [31:0] xo,
                              logic [31:0] yo, logic [31:0] xs, logic [31:0] ys,
                              logic [7:0] lim);
        write_cfg(jets_pkg::REG_C_RE, cr);
        write_cfg(jets_pkg::REG_C_IM, ci);
        write_cfg(jets_pkg::REG_X_ORIGIN, xo);
        write_cfg(jets_pkg::REG_Y_ORIGIN, yo);
        write_cfg(jets_pkg::REG_X_STEP, xs);
        write_cfg(jets_pkg::REG_Y_STEP, ys);
        write_cfg(jets_pkg::REG_ITER_LIM, {24'b0, lim});
    endtask

    task automatic random_phase(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0)
                send_pixel(10'($urandom), 10'($urandom));
            else
                send_pixel(10'($urandom_range(160)), 10'($urandom_range(120)));
        end
    endtask

    initial begin
        @(posedge i_rst_n);
        @(posedge i_clk);
        // directed: reset view, corners
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd160, 10'd120);
        send_pixel(10'd341, 10'd682);
        drain();
        // zero limit, then one
        write_cfg(jets_pkg::REG_ITER_LIM, 32'd0);
        send_pixel(10'd5, 10'd7);
        drain();
        write_cfg(jets_pkg::REG_ITER_LIM, 32'd1);
        send_pixel(10'd80, 10'd60);
        send_pixel(10'd0, 10'd0);
        drain();
        // extreme registers: saturating start points
        write_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h8000_0000, 8'd255);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd1, 10'd2);
        drain();
        // all-zero plane: every pixel stays at the limit
        write_view(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 8'd255);
        send_pixel(10'd3, 10'd9);
        send_pixel(10'd1023, 10'd512);
        drain();
        // start point on the escape boundary: escapes at count zero, below the limit
        write_view(32'd0, 32'd0, 32'h2000_0000, 32'd0, 32'd0, 32'd0, 8'd2);
        send_pixel(10'd0, 10'd0);
        drain();

        write_view(jets_pkg::RST_C_RE, jets_pkg::RST_C_IM, jets_pkg::RST_X_ORIGIN,
                   jets_pkg::RST_Y_ORIGIN, jets_pkg::RST_X_STEP, jets_pkg::RST_Y_STEP,
                   8'd30);
        send_idle_pct = 25;
        recv_idle_pct = 68;
        random_phase(350);
        drain();
        write_view(32'hF400_0000 + $urandom_range(32'h0800_0000), $urandom_range(32'h0400_0000),
                   32'hE800_0000, 32'hF000_0000, 32'h0030_0000, 32'h0040_0000, 8'd40);
        send_idle_pct = 68;
        recv_idle_pct = 25;
        random_phase(350);
        drain();
        write_view($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   8'($urandom_range(255)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(150);
        drain();
        write_view(jets_pkg::RST_C_RE, jets_pkg::RST_C_IM, jets_pkg::RST_X_ORIGIN,
                   jets_pkg::RST_Y_ORIGIN, jets_pkg::RST_X_STEP, jets_pkg::RST_Y_STEP,
                   8'd16);
        random_phase(350);
        drain();
        write_view(32'hF000_0000, 32'h0100_0000, 32'hE000_0000, 32'hE000_0000,
                   32'h0008_0000, 32'h0008_0000, 8'd12);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(330);
        drain();
        if (pixels.errors == 0 && pixels.expected_words.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

FILE: julia_escape_time_pixel_top.f
sv/jets_pkg.sv
sv/julia_escape_time_pixel_top.sv
tb/testbench.sv
